FILE: rtl/dlr_pkg.sv
package dlr_pkg;

   localparam int COORD_BITS_DEF = 11;
   localparam int QUOT_BITS      = 17;
   localparam int DEPTH_BITS     = 16;
   localparam int COLOUR_BITS    = 24;

   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   localparam logic [1:0] CH_DEPTH   = 2'd0;
   localparam logic [1:0] CH_COLOUR0 = 2'd1;
   localparam logic [1:0] CH_COLOUR1 = 2'd2;
   localparam logic [1:0] CH_LAST    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_WAIT,
      ST_SHOW
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PAT_1,
      PAT_2,
      PAT_3,
      PAT_4
   } pattern_type;

   typedef struct packed {
      logic       load;
      logic       mul;
      logic       div_go;
      logic       store;
      logic [1:0] pix;
      logic [1:0] ch;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] n_pixels;
      logic       div_done;
   } dp_status_type;

endpackage

FILE: rtl/dlr_div.sv
module dlr_div
   import dlr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [QUOT_BITS+COORD_BITS-1:0] dividend,
   input  logic [COORD_BITS-1:0]           divisor,
   output logic                            done,
   output logic [QUOT_BITS-1:0]            quotient
);

   localparam int CW = $clog2(QUOT_BITS);

   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [QUOT_BITS-1:0]  shf_ff, shf_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;
   logic                  ge;

   // restoring division, one quotient bit per cycle; quotient bits shift in
   // behind the dividend bits
   always_comb begin
      trial   = {rem_ff, shf_ff[QUOT_BITS-1]};
      ge      = trial >= {1'b0, divisor};
      diff    = trial - {1'b0, divisor};
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[QUOT_BITS +: COORD_BITS];
         shf_in  = dividend[QUOT_BITS-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         shf_in = {shf_ff[QUOT_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = shf_ff;

endmodule

FILE: rtl/dlr_dp.sv
module dlr_dp
   import dlr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status,
   input  logic                          func,
   input  logic [COORD_BITS-1:0]         start_x,
   input  logic [COORD_BITS-1:0]         start_y,
   input  logic signed [DEPTH_BITS-1:0]  start_depth,
   input  logic [COLOUR_BITS-1:0]        start_colour,
   input  logic [COORD_BITS-1:0]         end_x,
   input  logic [COORD_BITS-1:0]         end_y,
   input  logic signed [DEPTH_BITS-1:0]  end_depth,
   input  logic [COLOUR_BITS-1:0]        end_colour,
   output logic [COORD_BITS-1:0]         pixel_x,
   output logic [COORD_BITS-1:0]         pixel_y,
   output logic signed [DEPTH_BITS-1:0]  pixel_depth,
   output logic [COLOUR_BITS-1:0]        pixel_colour,
   output logic                          last_pixel
);

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 5;
   localparam int LW = QUOT_BITS + CB;
   localparam int SW = CB - 2;

   // line state
   logic                 active_ff, active_in;
   logic [CB-1:0]        fmaj_ff, fmaj_in, fmin_ff, fmin_in;
   logic [CB-1:0]        bmaj_ff, bmaj_in, bmin_ff, bmin_in;
   logic [CB-1:0]        origin_ff, origin_in;
   logic [CB-1:0]        mlen_ff, mlen_in, nlen_ff, nlen_in;
   logic signed [DW-1:0] dec_ff, dec_in;
   logic                 neg_step_ff, neg_step_in;
   logic                 swap_ff, swap_in;
   logic                 steep_ff, steep_in;
   logic [SW-1:0]        steps_ff, steps_in;
   logic [1:0]           tail_ff, tail_in;
   logic signed [DEPTH_BITS-1:0] bdepth_ff, bdepth_in;
   logic signed [DEPTH_BITS:0]   ddepth_ff, ddepth_in;
   logic [COLOUR_BITS-1:0]       bcol_ff, bcol_in;
   logic [26:0]                  dcol_ff, dcol_in;

   // pixels of the current item
   logic [CB-1:0] pmaj_ff [4];
   logic [CB-1:0] pmaj_in [4];
   logic [CB-1:0] pmin_ff [4];
   logic [CB-1:0] pmin_in [4];
   logic [3:0]    plast_ff, plast_in;
   logic [2:0]    n_ff, n_in;

   // start path
   logic [CB-1:0] dx_s, dy_s, ma1, mi1, ma2, mi2, ldx, ldy, ldx_m1;
   logic          swap_s, far_first;
   logic signed [DEPTH_BITS-1:0] zn, zf;
   logic [COLOUR_BITS-1:0]       cn, cf;
   logic signed [DW-1:0]         sdx, sdy;
   logic                         steep_s;

   // advance path
   logic signed [DW-1:0] adx, ady, cval, incr1, incr2;
   pattern_type          pat;
   logic [CB-1:0]        fo, so, third;
   logic [CB-1:0]        fm1, fm2, bm1, bm2, bm3;
   logic [SW-1:0]        steps_dec;
   logic                 last4;

   always_comb begin
      // start: order by major axis
      dx_s   = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
      dy_s   = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
      swap_s = dy_s > dx_s;
      ma1    = swap_s ? start_y : start_x;
      mi1    = swap_s ? start_x : start_y;
      ma2    = swap_s ? end_y : end_x;
      mi2    = swap_s ? end_x : end_y;
      ldx    = swap_s ? dy_s : dx_s;
      ldy    = swap_s ? dx_s : dy_s;
      far_first = ma1 > ma2;
      zn     = far_first ? end_depth : start_depth;
      zf     = far_first ? start_depth : end_depth;
      cn     = far_first ? end_colour : start_colour;
      cf     = far_first ? start_colour : end_colour;
      sdx    = $signed({5'b0, ldx});
      sdy    = $signed({5'b0, ldy});
      steep_s = {ldy, 1'b0} >= {1'b0, ldx};
      ldx_m1 = ldx - 1'b1;

      // advance: pick the pattern from the decision value
      adx   = $signed({5'b0, mlen_ff});
      ady   = $signed({5'b0, nlen_ff});
      cval  = steep_ff ? ((ady - adx) <<< 1) : (ady <<< 1);
      incr1 = cval <<< 1;
      incr2 = (ady <<< 2) - (adx <<< 1);
      if (steep_ff) begin
         pat = (dec_ff > 0) ? PAT_4 : ((dec_ff < cval) ? PAT_2 : PAT_3);
      end else begin
         pat = (dec_ff < 0) ? PAT_1 : ((dec_ff < cval) ? PAT_2 : PAT_3);
      end
      case (pat)
         PAT_1: begin
            fo = CB'(0); so = CB'(0); third = CB'(0);
         end
         PAT_2: begin
            fo = CB'(0); so = CB'(1); third = CB'(0);
         end
         PAT_3: begin
            fo = CB'(1); so = CB'(1);
            third = (steep_ff && !(dec_ff > cval)) ? CB'(0) : CB'(1);
         end
         default: begin
            fo = CB'(1); so = CB'(2); third = CB'(1);
         end
      endcase
      fm1 = neg_step_ff ? fmin_ff - fo : fmin_ff + fo;
      fm2 = neg_step_ff ? fmin_ff - so : fmin_ff + so;
      bm1 = neg_step_ff ? bmin_ff + fo : bmin_ff - fo;
      bm2 = neg_step_ff ? bmin_ff + so : bmin_ff - so;
      bm3 = neg_step_ff ? bmin_ff + third : bmin_ff - third;
      steps_dec = steps_ff - 1'b1;
      last4 = (steps_dec == '0) && (tail_ff == 2'd0);

      // hold by default
      active_in = active_ff;
      fmaj_in = fmaj_ff; fmin_in = fmin_ff; bmaj_in = bmaj_ff; bmin_in = bmin_ff;
      origin_in = origin_ff; mlen_in = mlen_ff; nlen_in = nlen_ff;
      dec_in = dec_ff; neg_step_in = neg_step_ff; swap_in = swap_ff;
      steep_in = steep_ff; steps_in = steps_ff; tail_in = tail_ff;
      bdepth_in = bdepth_ff; ddepth_in = ddepth_ff;
      bcol_in = bcol_ff; dcol_in = dcol_ff;
      for (int i = 0; i < 4; i++) begin
         pmaj_in[i] = pmaj_ff[i];
         pmin_in[i] = pmin_ff[i];
      end
      plast_in = plast_ff;
      n_in     = n_ff;

      if (func == FUNC_START) begin
         neg_step_in = (end_x < start_x) != (end_y < start_y);
         swap_in   = swap_s;
         fmaj_in   = far_first ? ma2 : ma1;
         fmin_in   = far_first ? mi2 : mi1;
         bmaj_in   = far_first ? ma1 : ma2;
         bmin_in   = far_first ? mi1 : mi2;
         origin_in = far_first ? ma2 : ma1;
         mlen_in   = ldx;
         nlen_in   = ldy;
         bdepth_in = zn;
         ddepth_in = {zf[DEPTH_BITS-1], zf} - {zn[DEPTH_BITS-1], zn};
         bcol_in   = cn;
         for (int k = 0; k < 3; k++) begin
            dcol_in[9*k +: 9] = {1'b0, cf[8*k +: 8]} - {1'b0, cn[8*k +: 8]};
         end
         steps_in  = ldx_m1[CB-1:2];
         tail_in   = ldx_m1[1:0];
         steep_in  = steep_s;
         dec_in    = steep_s ? (((sdy - sdx) <<< 2) + sdx) : ((sdy <<< 2) - sdx);
         pmaj_in[0] = far_first ? ma2 : ma1;
         pmin_in[0] = far_first ? mi2 : mi1;
         pmaj_in[1] = far_first ? ma1 : ma2;
         pmin_in[1] = far_first ? mi1 : mi2;
         plast_in   = {2'b00, ldx == CB'(1), ldx == '0};
         n_in       = (ldx == '0) ? 3'd1 : 3'd2;
         active_in  = ldx > CB'(1);
      end else if (!active_ff) begin
         n_in = 3'd0;
      end else if (steps_ff != '0) begin
         // one double step from both ends
         pmaj_in[0] = fmaj_ff + CB'(1); pmin_in[0] = fm1;
         pmaj_in[1] = fmaj_ff + CB'(2); pmin_in[1] = fm2;
         pmaj_in[2] = bmaj_ff - CB'(1); pmin_in[2] = bm1;
         pmaj_in[3] = bmaj_ff - CB'(2); pmin_in[3] = bm2;
         plast_in   = {last4, 3'b000};
         n_in       = 3'd4;
         steps_in   = steps_dec;
         fmaj_in    = fmaj_ff + CB'(2); fmin_in = fm2;
         bmaj_in    = bmaj_ff - CB'(2); bmin_in = bm2;
         dec_in     = dec_ff + (((pat == PAT_1) || (pat == PAT_4)) ? incr1 : incr2);
         active_in  = !last4;
      end else begin
         // final zero to three pixels
         pmaj_in[0] = fmaj_ff + CB'(1); pmin_in[0] = fm1;
         pmaj_in[1] = fmaj_ff + CB'(2); pmin_in[1] = fm2;
         pmaj_in[2] = bmaj_ff - CB'(1); pmin_in[2] = bm3;
         plast_in   = {1'b0, tail_ff == 2'd3, tail_ff == 2'd2, tail_ff == 2'd1};
         n_in       = {1'b0, tail_ff};
         tail_in    = 2'd0;
         active_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fmaj_ff <= fmaj_in; fmin_ff <= fmin_in; bmaj_ff <= bmaj_in; bmin_ff <= bmin_in;
         origin_ff <= origin_in; mlen_ff <= mlen_in; nlen_ff <= nlen_in;
         dec_ff <= dec_in; neg_step_ff <= neg_step_in; swap_ff <= swap_in;
         steep_ff <= steep_in; steps_ff <= steps_in; tail_ff <= tail_in;
         bdepth_ff <= bdepth_in; ddepth_ff <= ddepth_in;
         bcol_ff <= bcol_in; dcol_ff <= dcol_in;
         for (int i = 0; i < 4; i++) begin
            pmaj_ff[i] <= pmaj_in[i];
            pmin_ff[i] <= pmin_in[i];
         end
         plast_ff <= plast_in;
      end
      if (reset) begin
         active_ff <= 1'b0;
         n_ff      <= 3'd0;
      end else if (cmd.load) begin
         active_ff <= active_in;
         n_ff      <= n_in;
      end
   end

   // interpolation: one channel at a time through the shared divider
   logic [CB-1:0]                offset;
   logic signed [DEPTH_BITS:0]   delta_sel;
   logic signed [DEPTH_BITS-1:0] base_sel;
   logic [QUOT_BITS-1:0]         mag;
   logic [LW-1:0]                prod_ff;
   logic                         qneg_ff;
   logic signed [DEPTH_BITS-1:0] base_ff;
   logic                         zlen_ff;
   logic                         div_done;
   logic [QUOT_BITS-1:0]         quot;
   logic signed [QUOT_BITS:0]    qs;
   logic signed [QUOT_BITS:0]    sum;
   logic signed [DEPTH_BITS-1:0] depth_ff;
   logic [COLOUR_BITS-1:0]       colour_ff;

   always_comb begin
      offset = pmaj_ff[cmd.pix] - origin_ff;
      case (cmd.ch)
         CH_DEPTH: begin
            delta_sel = ddepth_ff;
            base_sel  = bdepth_ff;
         end
         CH_COLOUR0: begin
            delta_sel = {{8{dcol_ff[8]}}, dcol_ff[8:0]};
            base_sel  = {8'b0, bcol_ff[7:0]};
         end
         CH_COLOUR1: begin
            delta_sel = {{8{dcol_ff[17]}}, dcol_ff[17:9]};
            base_sel  = {8'b0, bcol_ff[15:8]};
         end
         default: begin
            delta_sel = {{8{dcol_ff[26]}}, dcol_ff[26:18]};
            base_sel  = {8'b0, bcol_ff[23:16]};
         end
      endcase
      mag = delta_sel[DEPTH_BITS] ? QUOT_BITS'(-delta_sel) : QUOT_BITS'(delta_sel);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= LW'(mag) * LW'(offset);
         qneg_ff <= delta_sel[DEPTH_BITS];
         base_ff <= base_sel;
         zlen_ff <= mlen_ff == '0;
      end
   end

   dlr_div #(
      .COORD_BITS(COORD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (prod_ff),
      .divisor  (mlen_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      if (zlen_ff) begin
         qs = '0;
      end else if (qneg_ff) begin
         qs = -$signed({1'b0, quot});
      end else begin
         qs = $signed({1'b0, quot});
      end
      sum = $signed({{2{base_ff[DEPTH_BITS-1]}}, base_ff}) + qs;
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.ch)
            CH_DEPTH:   depth_ff         <= sum[DEPTH_BITS-1:0];
            CH_COLOUR0: colour_ff[7:0]   <= sum[7:0];
            CH_COLOUR1: colour_ff[15:8]  <= sum[7:0];
            default:    colour_ff[23:16] <= sum[7:0];
         endcase
      end
   end

   assign status.n_pixels = n_ff;
   assign status.div_done = div_done;

   assign pixel_x      = swap_ff ? pmin_ff[cmd.pix] : pmaj_ff[cmd.pix];
   assign pixel_y      = swap_ff ? pmaj_ff[cmd.pix] : pmin_ff[cmd.pix];
   assign pixel_depth  = depth_ff;
   assign pixel_colour = colour_ff;
   assign last_pixel   = plast_ff[cmd.pix];

endmodule

FILE: rtl/dlr_ctrl.sv
module dlr_ctrl
   import dlr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     pix_ff, pix_in;
   logic [1:0]     ch_ff, ch_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pix_ff   <= 2'd0;
         ch_ff    <= CH_DEPTH;
      end else begin
         state_ff <= state_in;
         pix_ff   <= pix_in;
         ch_ff    <= ch_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pix_in     = pix_ff;
      ch_in      = ch_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.load   = 1'b0;
      cmd.mul    = 1'b0;
      cmd.div_go = 1'b0;
      cmd.store  = 1'b0;
      cmd.pix    = pix_ff;
      cmd.ch     = ch_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            pix_in   = 2'd0;
            ch_in    = CH_DEPTH;
            state_in = (status.n_pixels == 3'd0) ? ST_IDLE : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_go = 1'b1;
            state_in   = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_done) begin
               cmd.store = 1'b1;
               if (ch_ff == CH_LAST) begin
                  state_in = ST_SHOW;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if ({1'b0, pix_ff} == status.n_pixels - 3'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  pix_in   = pix_ff + 1'b1;
                  ch_in    = CH_DEPTH;
                  state_in = ST_MUL;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_div_not_instant: assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |=> !status.div_done)
      else $error("divider finished right after start");

   a_pix_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHOW |-> {1'b0, pix_ff} < status.n_pixels)
      else $error("pixel index beyond item pixel count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PREP |-> status.n_pixels <= 3'd4)
      else $error("more than four pixels for one item");

   a_wait_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && status.div_done) |=> (state_ff == ST_SHOW || state_ff == ST_MUL))
      else $error("channel store did not advance the sequence");

endmodule

FILE: rtl/double_step_line_rasterizer.sv
// Symmetric double-step line rasterizer. A start transfer (req_tuser 0) loads
// two endpoints and returns the near endpoint, then the far endpoint unless
// the line has zero length; each advance transfer (req_tuser 1) returns the
// four pixels of one double step, or the final zero to three pixels, and an
// advance with no line in progress returns nothing. Every pixel carries depth
// and three colour channels interpolated as base + delta*offset/length,
// truncated toward zero. One item is processed at a time: the block takes a
// new request only after all pixels of the previous one have been taken.
// Before each pixel is offered, depth and each colour channel pass in turn
// through a single multiplier and one shared 17-step restoring divider, and a
// request is accepted in the cycle after the last pixel's transfer.
module double_step_line_rasterizer
   import dlr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int REQ_W = ((4 * COORD_BITS + 80 + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + 40 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // start_x, start_y, start_depth, start_colour, end_x, end_y, end_depth, end_colour
   input  logic [REQ_W-1:0] req_tdata,
   // func: 0 start a line, 1 advance
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pixel_x, pixel_y, pixel_depth, pixel_colour
   output logic [RSP_W-1:0] rsp_tdata,
   // last_pixel
   output logic             rsp_tlast
);

   localparam int CB = COORD_BITS;

   dp_cmd_type    cmd;
   dp_status_type status;

   logic [CB-1:0]                pixel_x, pixel_y;
   logic signed [DEPTH_BITS-1:0] pixel_depth;
   logic [COLOUR_BITS-1:0]       pixel_colour;
   logic signed [DEPTH_BITS-1:0] start_depth, end_depth;

   // unpack request fields, lowest first
   assign start_depth = req_tdata[2*CB +: DEPTH_BITS];
   assign end_depth   = req_tdata[4*CB+40 +: DEPTH_BITS];

   dlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   dlr_dp #(
      .COORD_BITS(COORD_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .func         (req_tuser),
      .start_x      (req_tdata[0 +: CB]),
      .start_y      (req_tdata[CB +: CB]),
      .start_depth  (start_depth),
      .start_colour (req_tdata[2*CB+16 +: COLOUR_BITS]),
      .end_x        (req_tdata[2*CB+40 +: CB]),
      .end_y        (req_tdata[3*CB+40 +: CB]),
      .end_depth    (end_depth),
      .end_colour   (req_tdata[4*CB+56 +: COLOUR_BITS]),
      .pixel_x      (pixel_x),
      .pixel_y      (pixel_y),
      .pixel_depth  (pixel_depth),
      .pixel_colour (pixel_colour),
      .last_pixel   (rsp_tlast)
   );

   // pack the pixel, zero-fill to whole bytes
   assign rsp_tdata = RSP_W'({pixel_colour, pixel_depth, pixel_y, pixel_x});

endmodule
